// ===== src/ldf_pkg.sv =====
// Shared types and constants for the length-prefixed packet deframer.
package ldf_pkg;

    localparam logic [7:0] SYNC_A = 8'd205;
    localparam logic [7:0] SYNC_B = 8'd235;
    localparam logic [7:0] SYNC_C = 8'd215;

    // Payload position and length travel at this width (covers the whole parameter range)
    localparam int IDX_W = 8;
    // Output fields are five bits wide
    localparam int FIELD_W = 5;
    // Depth of the request queue between front and back
    localparam int QUEUE_DEPTH = 4;

    // One store request from the front to the back
    typedef struct packed {
        logic [7:0]       data;
        logic [IDX_W-1:0] index;
        logic             finish;
    } ldf_cmd_t;

endpackage

// ===== src/ldf_front.sv =====
// Front part: sync detection, length tracking and classification of received bytes.
module ldf_front #(
    parameter int MAX_PAYLOAD = 20
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    input  logic             in_ready,
    input  logic [7:0]       rx_byte,
    output logic             push,
    output ldf_pkg::ldf_cmd_t cmd
);
    import ldf_pkg::*;

    localparam logic [IDX_W-1:0] MAX_LEN = IDX_W'(MAX_PAYLOAD);

    logic [7:0]       older_byte_reg, older_byte_next;
    logic [7:0]       newer_byte_reg, newer_byte_next;
    logic             awaiting_reg, awaiting_next;
    logic [IDX_W-1:0] expected_reg, expected_next;
    logic [IDX_W-1:0] count_reg, count_next;

    logic sync;
    logic store;
    logic finish;
    logic accept;

    assign accept = in_valid && in_ready;
    assign sync   = (older_byte_reg == SYNC_A) && (newer_byte_reg == SYNC_B)
                 && (rx_byte == SYNC_C);
    assign store  = !sync && !awaiting_reg && (expected_reg > count_reg)
                 && (expected_reg <= MAX_LEN);
    assign finish = store && ((count_reg + IDX_W'(1)) == expected_reg);

    assign push        = accept && store;
    assign cmd.data    = rx_byte;
    assign cmd.index   = count_reg;
    assign cmd.finish  = finish;

    always_comb
    begin
        older_byte_next = older_byte_reg;
        newer_byte_next = newer_byte_reg;
        awaiting_next   = awaiting_reg;
        expected_next   = expected_reg;
        count_next      = count_reg;
        if (accept)
        begin
            older_byte_next = newer_byte_reg;
            newer_byte_next = rx_byte;
            if (sync)
            begin
                // drop any partial packet, next byte is a length
                awaiting_next = 1'b1;
                expected_next = '0;
                count_next    = '0;
            end
            else if (awaiting_reg)
            begin
                awaiting_next = 1'b0;
                expected_next = rx_byte;
            end
            else if (store)
            begin
                if (finish)
                begin
                    expected_next = '0;
                    count_next    = '0;
                end
                else
                begin
                    count_next = count_reg + IDX_W'(1);
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            older_byte_reg <= '0;
            newer_byte_reg <= '0;
            awaiting_reg   <= 1'b0;
            expected_reg   <= '0;
            count_reg      <= '0;
        end
        else
        begin
            older_byte_reg <= older_byte_next;
            newer_byte_reg <= newer_byte_next;
            awaiting_reg   <= awaiting_next;
            expected_reg   <= expected_next;
            count_reg      <= count_next;
        end
    end

endmodule

// ===== src/ldf_queue.sv =====
// Short request queue between the front and back parts.
module ldf_queue (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  ldf_pkg::ldf_cmd_t push_cmd,
    output logic              full,
    input  logic              pop,
    output logic              not_empty,
    output ldf_pkg::ldf_cmd_t head_cmd
);
    import ldf_pkg::*;

    localparam int PTR_W = $clog2(QUEUE_DEPTH);
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    ldf_cmd_t         entry_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] fill_reg, fill_next;

    assign full      = (fill_reg == CNT_W'(QUEUE_DEPTH));
    assign not_empty = (fill_reg != '0);
    assign head_cmd  = entry_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + PTR_W'(1) : wr_ptr_reg;
        rd_ptr_next = pop  ? rd_ptr_reg + PTR_W'(1) : rd_ptr_reg;
        fill_next   = fill_reg;
        if (push && !pop)
        begin
            fill_next = fill_reg + CNT_W'(1);
        end
        else if (pop && !push)
        begin
            fill_next = fill_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_cmd;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

endmodule

// ===== src/ldf_back.sv =====
// Back part: payload buffer and byte-by-byte emission of completed packets.
module ldf_back #(
    parameter int MAX_PAYLOAD = 20
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cmd_valid,
    input  ldf_pkg::ldf_cmd_t             cmd,
    output logic                          cmd_pop,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [7:0]                    payload_byte,
    output logic [ldf_pkg::FIELD_W-1:0]   byte_index,
    output logic [ldf_pkg::FIELD_W-1:0]   packet_length,
    output logic                          last_byte
);
    import ldf_pkg::*;

    localparam int ADDR_W = (MAX_PAYLOAD > 1) ? $clog2(MAX_PAYLOAD) : 1;

    typedef enum logic [1:0] {
        S_IDLE,
        S_READ,
        S_SEND
    } state_t;

    state_t           state_reg;
    logic [IDX_W-1:0] emit_idx_reg;
    logic [IDX_W-1:0] len_reg;
    logic             out_valid_reg;
    logic             last_reg;

    logic [7:0]       mem [MAX_PAYLOAD];
    logic [7:0]       rd_data_reg;
    logic             wr_en;
    logic [ADDR_W-1:0] wr_addr;
    logic [ADDR_W-1:0] rd_addr;

    assign cmd_pop = (state_reg == S_IDLE) && cmd_valid;
    assign wr_en   = cmd_pop;
    assign wr_addr = cmd.index[ADDR_W-1:0];
    assign rd_addr = emit_idx_reg[ADDR_W-1:0];

    assign out_valid     = out_valid_reg;
    assign payload_byte  = rd_data_reg;
    assign byte_index    = emit_idx_reg[FIELD_W-1:0];
    assign packet_length = len_reg[FIELD_W-1:0];
    assign last_byte     = last_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= cmd.data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            emit_idx_reg  <= '0;
            len_reg       <= '0;
            out_valid_reg <= 1'b0;
            last_reg      <= 1'b0;
        end
        else
        begin
            case (state_reg)
                S_IDLE:
                begin
                    if (cmd_valid && cmd.finish)
                    begin
                        len_reg      <= cmd.index + IDX_W'(1);
                        emit_idx_reg <= '0;
                        state_reg    <= S_READ;
                    end
                end
                S_READ:
                begin
                    // read data lands this edge; hold it for the request
                    out_valid_reg <= 1'b1;
                    last_reg      <= ((emit_idx_reg + IDX_W'(1)) == len_reg);
                    state_reg     <= S_SEND;
                end
                S_SEND:
                begin
                    if (out_ready)
                    begin
                        out_valid_reg <= 1'b0;
                        if (last_reg)
                        begin
                            state_reg <= S_IDLE;
                        end
                        else
                        begin
                            emit_idx_reg <= emit_idx_reg + IDX_W'(1);
                            state_reg    <= S_READ;
                        end
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

`ifndef ASSERT_OFF
    a_idx_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (emit_idx_reg < len_reg))
        else $error("emitted index beyond packet length");

    a_no_pop_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != S_IDLE) |-> !cmd_pop)
        else $error("buffer written while a packet is being emitted");

    a_last_ends: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_ready && last_reg) |=> (state_reg == S_IDLE))
        else $error("emission did not end after the final byte");

    a_len_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> ((len_reg != '0) && (len_reg <= IDX_W'(MAX_PAYLOAD))))
        else $error("packet length outside the buffer range");
`endif

endmodule

// ===== src/length_prefixed_packet_deframer.sv =====
// Top level of the length-prefixed packet deframer: front, request queue and back.
// Input: one byte per cycle while the request queue has room (four entries).
// Output: payload bytes one at a time, each with a buffer read state, then a send state held until out_ready is high.
// With the queue empty, a packet's final byte passes the request queue, S_IDLE and S_READ before out_valid rises.
// While a packet is being emitted, the back part pops no requests from the queue.
// Reset (rst_n low, asynchronous) clears sync history, length tracking and queue; buffer is not cleared.
module length_prefixed_packet_deframer #(
    parameter int MAX_PAYLOAD = 20
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    output logic                        in_ready,
    input  logic [7:0]                  rx_byte,
    output logic                        out_valid,
    input  logic                        out_ready,
    output logic [7:0]                  payload_byte,
    output logic [ldf_pkg::FIELD_W-1:0] byte_index,
    output logic [ldf_pkg::FIELD_W-1:0] packet_length,
    output logic                        last_byte
);
    import ldf_pkg::*;

    logic     push;
    ldf_cmd_t push_cmd;
    logic     queue_full;
    logic     queue_not_empty;
    logic     pop;
    ldf_cmd_t head_cmd;

    // Take a new byte whenever the queue can absorb a store request; ignored
    // bytes and sync bytes push nothing but still wait for room.
    assign in_ready = !queue_full;

    // Front: track the last two bytes for the sync pattern, take the length
    // byte, and turn each payload byte into a store request.
    ldf_front #(
        .MAX_PAYLOAD (MAX_PAYLOAD)
    ) u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .rx_byte  (rx_byte),
        .push     (push),
        .cmd      (push_cmd)
    );

    // Queue: decouple byte intake from packet emission.
    ldf_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_cmd  (push_cmd),
        .full      (queue_full),
        .pop       (pop),
        .not_empty (queue_not_empty),
        .head_cmd  (head_cmd)
    );

    // Back: write payload bytes into the buffer and, on the final byte,
    // replay the whole packet one byte at a time; hold the queue meanwhile.
    ldf_back #(
        .MAX_PAYLOAD (MAX_PAYLOAD)
    ) u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd_valid     (queue_not_empty),
        .cmd           (head_cmd),
        .cmd_pop       (pop),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .payload_byte  (payload_byte),
        .byte_index    (byte_index),
        .packet_length (packet_length),
        .last_byte     (last_byte)
    );

endmodule

// ===== tb/tb_top.sv =====
// Self-checking testbench for the length-prefixed packet deframer.
module tb_top;

    import ldf_pkg::*;

    localparam int MAX_PAYLOAD    = 20;
    localparam int RANDOM_ITEMS   = 370;  // framed bytes in the random part
    localparam int CALM_AFTER     = 330;  // no idling on either side past this point
    localparam int HOLD_OFF_LEN   = 80;   // long receiver stall, in cycles
    localparam int WATCHDOG_LIMIT = 2000; // cycles with no request moving on either side
    localparam int DRAIN_CYCLES   = 20;

    // One payload byte as it leaves the block
    typedef struct packed {
        logic [7:0]         data;
        logic [FIELD_W-1:0] pos;
        logic [FIELD_W-1:0] len;
        logic               tail;
    } payload_beat_t;

    // One directed request; a fixed row carries its result typed in by hand
    typedef struct packed {
        logic [7:0]    rx;
        logic          fixed;
        logic          emits;
        payload_beat_t beat;
    } stim_row_t;

    localparam payload_beat_t NO_BEAT = '0;
    localparam int DIR_ROWS = 31;

    logic                clk;
    logic                rst_n;
    logic                in_valid;
    logic                in_ready;
    logic [7:0]          rx_byte;
    logic                out_valid;
    logic                out_ready;
    logic [7:0]          payload_byte;
    logic [FIELD_W-1:0]  byte_index;
    logic [FIELD_W-1:0]  packet_length;
    logic                last_byte;

    length_prefixed_packet_deframer #(
        .MAX_PAYLOAD(MAX_PAYLOAD)
    ) dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .rx_byte       (rx_byte),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .payload_byte  (payload_byte),
        .byte_index    (byte_index),
        .packet_length (packet_length),
        .last_byte     (last_byte)
    );

    // ------------------------------------------------------------------
    // Clock: period 10, starts low
    // ------------------------------------------------------------------
    initial clk = 1'b0;
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Deframer predictor: own copy of the sync history, length tracking
    // and payload buffer. Each accepted byte leaves its results, if any,
    // in completed_beats.
    // ------------------------------------------------------------------
    logic [7:0]         hist_old;
    logic [7:0]         hist_new;
    logic               want_len;
    logic [7:0]         frame_len;
    logic [4:0]         fill_cnt;
    logic [7:0]         frame_buf [MAX_PAYLOAD];
    payload_beat_t      completed_beats [$];

    // Payload bytes still owed by the block, oldest first
    payload_beat_t      owed_beats [$];

    task automatic deframe_byte(input logic [7:0] b);
        logic          is_sync;
        payload_beat_t beat;
        is_sync = (hist_old == SYNC_A) && (hist_new == SYNC_B) && (b == SYNC_C);
        hist_old = hist_new;
        hist_new = b;
        completed_beats.delete();
        if (is_sync)
        begin
            // Drop any partial frame and take the next byte as a length
            want_len  = 1'b1;
            frame_len = '0;
            fill_cnt  = '0;
        end
        else if (want_len)
        begin
            frame_len = b;
            want_len  = 1'b0;
        end
        else if (frame_len > fill_cnt && frame_len <= MAX_PAYLOAD)
        begin
            frame_buf[fill_cnt] = b;
            fill_cnt = fill_cnt + 5'd1;
            if (fill_cnt == frame_len)
            begin
                for (int k = 0; k < frame_len; k++)
                begin
                    beat.data = frame_buf[k];
                    beat.pos  = k[FIELD_W-1:0];
                    beat.len  = frame_len[FIELD_W-1:0];
                    beat.tail = (k == frame_len - 1);
                    completed_beats.push_back(beat);
                end
                // Ignore everything until the next sync
                frame_len = '0;
                fill_cnt  = '0;
            end
        end
    endtask

    // ------------------------------------------------------------------
    // Scoreboard. A single process handles both sides at the rising edge,
    // so a prediction always lands before the matching output is checked.
    // ------------------------------------------------------------------
    int            error_count;
    int            requests_in;
    int            beats_checked;
    logic          row_fixed;
    logic          row_emits;
    payload_beat_t row_beat;

    always @(posedge clk)
    begin
        payload_beat_t want;
        if (rst_n)
        begin
            if (in_valid && in_ready)
            begin
                requests_in++;
                deframe_byte(rx_byte);
                if (row_fixed)
                begin
                    // Trust the hand-typed result for this row
                    if (row_emits)
                        owed_beats.push_back(row_beat);
                end
                else
                begin
                    foreach (completed_beats[k])
                        owed_beats.push_back(completed_beats[k]);
                end
            end
            if (out_valid && out_ready)
            begin
                if (owed_beats.size() == 0)
                begin
                    $error("unexpected payload byte %0d (index %0d, length %0d)",
                           payload_byte, byte_index, packet_length);
                    error_count++;
                end
                else
                begin
                    want = owed_beats.pop_front();
                    beats_checked++;
                    if (payload_byte !== want.data)
                    begin
                        $error("payload_byte: expected %0d, got %0d", want.data, payload_byte);
                        error_count++;
                    end
                    if (byte_index !== want.pos)
                    begin
                        $error("byte_index: expected %0d, got %0d", want.pos, byte_index);
                        error_count++;
                    end
                    if (packet_length !== want.len)
                    begin
                        $error("packet_length: expected %0d, got %0d", want.len, packet_length);
                        error_count++;
                    end
                    if (last_byte !== want.tail)
                    begin
                        $error("last_byte: expected %0d, got %0d", want.tail, last_byte);
                        error_count++;
                    end
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Watchdog: end the run if no request moves for too long
    // ------------------------------------------------------------------
    int quiet_cycles;

    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready))
            quiet_cycles <= 0;
        else
        begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles == WATCHDOG_LIMIT)
            begin
                $display("stalled with %0d payload bytes still owed", owed_beats.size());
                $display("DONE: errors detected");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------
    // Receiver: random stall bursts, a long hold-off on request, and no
    // stalls at all once the run turns calm.
    // ------------------------------------------------------------------
    bit calm;
    bit hold_off_req;
    int recv_idle_pct;

    initial
    begin
        int stall_left;
        int phase_cnt;
        out_ready     = 1'b0;
        stall_left    = 0;
        phase_cnt     = 0;
        recv_idle_pct = 15;
        forever
        begin
            @(negedge clk);
            // Re-pick the stall density now and then, zero included
            phase_cnt++;
            if (phase_cnt == 50)
            begin
                phase_cnt = 0;
                case ($urandom_range(0, 2))
                    0:       recv_idle_pct = 0;
                    1:       recv_idle_pct = 15;
                    default: recv_idle_pct = 40;
                endcase
            end
            if (hold_off_req)
            begin
                // Hold off long enough for the request queue to fill
                hold_off_req = 1'b0;
                out_ready <= 1'b0;
                repeat (HOLD_OFF_LEN) @(negedge clk);
            end
            else if (calm)
                out_ready <= 1'b1;
            else if (stall_left > 0)
            begin
                out_ready <= 1'b0;
                stall_left--;
            end
            else if ($urandom_range(0, 99) < recv_idle_pct)
            begin
                out_ready <= 1'b0;
                stall_left = $urandom_range(1, 7) - 1;
            end
            else
                out_ready <= 1'b1;
        end
    end

    // ------------------------------------------------------------------
    // Sender: offer one byte, optionally after an idle burst, and hold it
    // until the block takes it.
    // ------------------------------------------------------------------
    int send_idle_pct;

    task automatic offer_byte(input logic [7:0] b, input logic fixed,
                              input logic emits, input payload_beat_t beat);
        int gap;
        gap = 0;
        if (!calm && $urandom_range(0, 99) < send_idle_pct)
            gap = $urandom_range(1, 7);
        @(negedge clk);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        row_fixed = fixed;
        row_emits = emits;
        row_beat  = beat;
        in_valid <= 1'b1;
        rx_byte  <= b;
        do
            @(posedge clk);
        while (!in_ready);
    endtask

    // ------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------
    stim_row_t dir_rows [DIR_ROWS];

    initial
    begin
        int   random_items;
        int   frames_sent;
        int   longest;
        int   len;
        int   n;
        int   r;
        bit   first_hold_done;
        bit   second_hold_done;
        logic [7:0] pb;

        rst_n         = 1'b0;
        in_valid      = 1'b0;
        rx_byte       = '0;
        row_fixed     = 1'b0;
        row_emits     = 1'b0;
        row_beat      = NO_BEAT;
        error_count   = 0;
        requests_in   = 0;
        beats_checked = 0;
        calm          = 1'b0;
        hold_off_req  = 1'b0;
        send_idle_pct = 10;
        hist_old      = '0;
        hist_new      = '0;
        want_len      = 1'b0;
        frame_len     = '0;
        fill_cnt      = '0;
        random_items  = 0;
        frames_sent   = 0;
        longest       = 0;
        first_hold_done  = 1'b0;
        second_hold_done = 1'b0;

        dir_rows = '{
            // ignored before any sync has been seen
            '{8'h00,  1'b1, 1'b0, NO_BEAT},
            '{SYNC_A, 1'b1, 1'b0, NO_BEAT},
            '{SYNC_B, 1'b1, 1'b0, NO_BEAT},
            '{SYNC_C, 1'b1, 1'b0, NO_BEAT},
            // shortest frame, all-ones payload
            '{8'd1,   1'b1, 1'b0, NO_BEAT},
            '{8'hFF,  1'b1, 1'b1, '{8'hFF, 5'd0, 5'd1, 1'b1}},
            // ignored once the frame is complete
            '{8'h00,  1'b1, 1'b0, NO_BEAT},
            // zero length: following bytes ignored
            '{SYNC_A, 1'b1, 1'b0, NO_BEAT},
            '{SYNC_B, 1'b1, 1'b0, NO_BEAT},
            '{SYNC_C, 1'b1, 1'b0, NO_BEAT},
            '{8'd0,   1'b1, 1'b0, NO_BEAT},
            '{8'h55,  1'b1, 1'b0, NO_BEAT},
            // one past the largest length: following bytes ignored
            '{SYNC_A, 1'b1, 1'b0, NO_BEAT},
            '{SYNC_B, 1'b1, 1'b0, NO_BEAT},
            '{SYNC_C, 1'b1, 1'b0, NO_BEAT},
            '{8'd21,  1'b1, 1'b0, NO_BEAT},
            '{8'hAA,  1'b1, 1'b0, NO_BEAT},
            // sync in the length slot, right after the previous one
            '{SYNC_A, 1'b0, 1'b0, NO_BEAT},
            '{SYNC_B, 1'b0, 1'b0, NO_BEAT},
            '{SYNC_C, 1'b0, 1'b0, NO_BEAT},
            '{SYNC_A, 1'b0, 1'b0, NO_BEAT},
            '{SYNC_B, 1'b0, 1'b0, NO_BEAT},
            '{SYNC_C, 1'b0, 1'b0, NO_BEAT},
            // sync inside a payload drops the partial frame
            '{8'd5,   1'b0, 1'b0, NO_BEAT},
            '{8'h11,  1'b0, 1'b0, NO_BEAT},
            '{SYNC_A, 1'b0, 1'b0, NO_BEAT},
            '{SYNC_B, 1'b0, 1'b0, NO_BEAT},
            '{SYNC_C, 1'b0, 1'b0, NO_BEAT},
            // two-byte frame right after the drop
            '{8'd2,   1'b0, 1'b0, NO_BEAT},
            '{8'h00,  1'b0, 1'b0, NO_BEAT},
            '{8'hFF,  1'b0, 1'b0, NO_BEAT}
        };

        // Hold reset, then release it on a falling edge
        repeat (8) @(negedge clk);
        rst_n = 1'b1;

        // Directed part: walk the table
        foreach (dir_rows[i])
            offer_byte(dir_rows[i].rx, dir_rows[i].fixed, dir_rows[i].emits,
                       dir_rows[i].beat);

        // Random part: mostly well-formed frames with random content,
        // sprinkled with bad lengths, cut-short frames, broken syncs and line noise
        while (random_items < RANDOM_ITEMS)
        begin
            calm = (random_items > CALM_AFTER);
            case ($urandom_range(0, 2))
                0:       send_idle_pct = 0;
                1:       send_idle_pct = 10;
                default: send_idle_pct = 30;
            endcase

            // Two long receiver hold-offs while frames keep arriving
            if (!first_hold_done && random_items > 80)
            begin
                hold_off_req    = 1'b1;
                first_hold_done = 1'b1;
            end
            if (!second_hold_done && random_items > 240)
            begin
                hold_off_req     = 1'b1;
                second_hold_done = 1'b1;
            end

            r = $urandom_range(0, 99);
            if (r < 6)
            begin
                // Line noise, not counted as stimulus
                n = $urandom_range(1, 4);
                repeat (n)
                    offer_byte(8'($urandom_range(0, 255)), 1'b0, 1'b0, NO_BEAT);
            end
            else if (r < 10)
            begin
                // Broken sync: first two bytes right, third wrong
                offer_byte(SYNC_A, 1'b0, 1'b0, NO_BEAT);
                offer_byte(SYNC_B, 1'b0, 1'b0, NO_BEAT);
                do
                    pb = 8'($urandom_range(0, 255));
                while (pb == SYNC_C);
                offer_byte(pb, 1'b0, 1'b0, NO_BEAT);
            end
            else
            begin
                r = $urandom_range(0, 99);
                if (r < 5)
                    len = 0;
                else if (r < 10)
                    len = $urandom_range(MAX_PAYLOAD + 1, 255);
                else if (r < 16)
                    len = MAX_PAYLOAD;
                else if (r < 40)
                    len = $urandom_range(1, MAX_PAYLOAD);
                else
                    len = $urandom_range(1, 6);

                if (len >= 1 && len <= MAX_PAYLOAD)
                begin
                    n = len;
                    // Cut some frames short; the next sync drops them
                    if ($urandom_range(0, 99) < 8)
                        n = $urandom_range(0, len - 1);
                    else if (len > longest)
                        longest = len;
                end
                else
                    n = $urandom_range(0, 4);

                offer_byte(SYNC_A, 1'b0, 1'b0, NO_BEAT);
                offer_byte(SYNC_B, 1'b0, 1'b0, NO_BEAT);
                offer_byte(SYNC_C, 1'b0, 1'b0, NO_BEAT);
                offer_byte(8'(len), 1'b0, 1'b0, NO_BEAT);
                random_items += 4;
                frames_sent++;
                repeat (n)
                begin
                    // Lace payloads with a sync lead-in byte now and then
                    if ($urandom_range(0, 19) == 0)
                        pb = SYNC_A;
                    else
                        pb = 8'($urandom_range(0, 255));
                    offer_byte(pb, 1'b0, 1'b0, NO_BEAT);
                    random_items++;
                end

                // Trailing bytes after a complete frame are ignored by the block; after a cut-short one they are stored
                if ($urandom_range(0, 4) == 0)
                begin
                    n = $urandom_range(1, 3);
                    repeat (n)
                        offer_byte(8'($urandom_range(0, 255)), 1'b0, 1'b0, NO_BEAT);
                end
            end
        end

        // Stop offering and let the block drain
        @(negedge clk);
        in_valid <= 1'b0;
        while (owed_beats.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Sent %0d bytes (%0d directed), %0d random frames announced, longest %0d",
                 requests_in, DIR_ROWS, frames_sent, longest);
        $display("Compared %0d payload bytes through two long receiver hold-offs",
                 beats_checked);
        if (error_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule

// ===== sim.f =====
src/ldf_pkg.sv
src/ldf_front.sv
src/ldf_queue.sv
src/ldf_back.sv
src/length_prefixed_packet_deframer.sv
tb/tb_top.sv
